FILE: src/lgrs_pkg.sv
package lgrs_pkg;

  // width of the row width register
  localparam int ROW_WIDTH_W = 7;

  // row width after reset: every lane in use
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 7'd64;

  // neighbour count of one cell, eight neighbours at most
  typedef logic [3:0] nbr_count_t;

  // life rule b3/s23
  localparam nbr_count_t BIRTH_COUNT   = 4'd3;
  localparam nbr_count_t SURVIVE_COUNT = 4'd2;

endpackage

FILE: src/life_generation_row_stepper_unit.sv
// channel  | direction | tdata                 | tuser     | tlast
// ---------+-----------+-----------------------+-----------+-----------
// s_*      | in        | row_cells             | first_row | final_row
// m_*      | out       | next_row_cells        | run_last  | grid_end
// cfg_*    | in        | cfg_wr_data: row_width, written when cfg_wr_en is high
//
// one word is accepted per cycle while s_tready is high; a word in the middle
// of the grid gives its result via the work stage, then the output register.
// a bottom row that is not also a top row gives two words and holds its stage
// until both are made by the single shared generation unit. a top row that
// is not a bottom row gives no word. reset (rst, synchronous) clears the held
// rows, empties both stages and sets row_width to 64. an empty output register
// takes the stage's word even with m_tready low; a full one holds while
// m_tready is low and, once the work stage is also full, s_tready drops.
module life_generation_row_stepper_unit
  import lgrs_pkg::*;
#(
  parameter int MAX_WIDTH = 64,
  localparam int TDATA_W  = ((MAX_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // row width register
  input  logic                   cfg_wr_en,
  input  logic [ROW_WIDTH_W-1:0] cfg_wr_data,
  // input rows
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_W-1:0]     s_tdata,   // row_cells, zero padding
  input  logic                   s_tuser,   // first_row
  input  logic                   s_tlast,   // final_row
  // result rows
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_W-1:0]     m_tdata,   // next_row_cells, zero padding
  output logic                   m_tuser,   // run_last
  output logic                   m_tlast    // grid_end
);

  logic [ROW_WIDTH_W-1:0] row_width;
  logic [MAX_WIDTH-1:0]   lane_mask;
  logic [MAX_WIDTH-1:0]   in_row;

  // held rows of the current grid
  logic [MAX_WIDTH-1:0] upper_row;
  logic [MAX_WIDTH-1:0] middle_row;

  // work stage
  logic                 s1_valid;
  logic                 s1_need_a;
  logic                 s1_need_b;
  logic                 s1_first;
  logic [MAX_WIDTH-1:0] s1_upper;
  logic [MAX_WIDTH-1:0] s1_middle;
  logic [MAX_WIDTH-1:0] s1_row;

  // output register
  logic [MAX_WIDTH-1:0] out_row;

  logic                 in_fire;
  logic                 out_load;
  logic                 s1_done;
  logic                 emit_a;
  logic [MAX_WIDTH-1:0] op_above;
  logic [MAX_WIDTH-1:0] op_mid;
  logic [MAX_WIDTH-1:0] op_below;
  logic [MAX_WIDTH-1:0] gen_row;

  // row width register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RESET;
    end else if (cfg_wr_en) begin
      row_width <= cfg_wr_data;
    end
  end

  // lanes at and above the width are dead
  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_mask
    assign lane_mask[i] = ROW_WIDTH_W'(i) < row_width;
  end

  assign in_row = s_tdata[MAX_WIDTH-1:0] & lane_mask;

  // handshake
  assign emit_a   = s1_need_a;
  assign out_load = s1_valid && (!m_tvalid || m_tready);
  assign s1_done  = out_load && (!s1_need_a || !s1_need_b);
  assign s_tready = !s1_valid || s1_done;
  assign in_fire  = s_tvalid && s_tready;

  // held rows shift on every accepted word; a first row clears the upper row
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_row  <= '0;
      middle_row <= '0;
    end else if (in_fire) begin
      upper_row  <= s_tuser ? '0 : middle_row;
      middle_row <= in_row;
    end
  end

  // work stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_need_a <= 1'b0;
      s1_need_b <= 1'b0;
    end else if (in_fire) begin
      s1_valid  <= !s_tuser || s_tlast;
      s1_need_a <= !s_tuser;
      s1_need_b <= s_tlast;
    end else if (s1_done) begin
      s1_valid  <= 1'b0;
      s1_need_a <= 1'b0;
      s1_need_b <= 1'b0;
    end else if (out_load) begin
      s1_need_a <= 1'b0;
    end
  end

  // work stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_first  <= s_tuser;
      s1_upper  <= upper_row;
      s1_middle <= middle_row;
      s1_row    <= in_row;
    end
  end

  // operands: middle row first, then the bottom row over a dead row
  always_comb begin
    if (emit_a) begin
      op_above = s1_upper;
      op_mid   = s1_middle;
      op_below = s1_row;
    end else begin
      op_above = s1_first ? '0 : s1_middle;
      op_mid   = s1_row;
      op_below = '0;
    end
  end

  lgrs_next_gen #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_next_gen (
    .above     (op_above),
    .mid       (op_mid),
    .below     (op_below),
    .lane_mask (lane_mask),
    .next_row  (gen_row)
  );

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row <= gen_row;
      m_tlast <= !emit_a;
      m_tuser <= !emit_a || !s1_need_b;
    end
  end

  assign m_tdata = TDATA_W'(out_row);

endmodule

FILE: src/lgrs_next_gen.sv
module lgrs_next_gen
  import lgrs_pkg::*;
#(
  parameter int MAX_WIDTH = 64
) (
  input  logic [MAX_WIDTH-1:0] above,
  input  logic [MAX_WIDTH-1:0] mid,
  input  logic [MAX_WIDTH-1:0] below,
  input  logic [MAX_WIDTH-1:0] lane_mask,
  output logic [MAX_WIDTH-1:0] next_row
);

  // rows with a dead cell on either edge, lanes beyond the mask dead
  logic [MAX_WIDTH+1:0] above_ext;
  logic [MAX_WIDTH+1:0] mid_ext;
  logic [MAX_WIDTH+1:0] below_ext;

  assign above_ext = {1'b0, above & lane_mask, 1'b0};
  assign mid_ext   = {1'b0, mid & lane_mask, 1'b0};
  assign below_ext = {1'b0, below & lane_mask, 1'b0};

  // one independent count and rule per lane
  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_lane
    nbr_count_t count;
    logic       alive;

    assign count = nbr_count_t'(above_ext[i]) + nbr_count_t'(above_ext[i+1])
                 + nbr_count_t'(above_ext[i+2]) + nbr_count_t'(mid_ext[i])
                 + nbr_count_t'(mid_ext[i+2]) + nbr_count_t'(below_ext[i])
                 + nbr_count_t'(below_ext[i+1]) + nbr_count_t'(below_ext[i+2]);

    assign alive = (count == BIRTH_COUNT) || ((count == SURVIVE_COUNT) && mid_ext[i+1]);

    assign next_row[i] = alive && lane_mask[i];
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import lgrs_pkg::*;

  localparam int CELLS = 64;

  // one input row word and one result row word
  typedef struct packed {
    logic [CELLS-1:0] cells;
    logic             top;
    logic             bottom;
  } row_word_t;

  typedef struct packed {
    logic [CELLS-1:0] cells;
    logic             grid_end;
    logic             run_last;
  } result_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [ROW_WIDTH_W-1:0] cfg_wr_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [CELLS-1:0]       s_tdata = '0;   // row_cells
  logic                   s_tuser = 1'b0; // first_row
  logic                   s_tlast = 1'b0; // final_row
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [CELLS-1:0]       m_tdata;        // next_row_cells
  logic                   m_tuser;        // run_last
  logic                   m_tlast;        // grid_end

  row_word_t    pending_rows[$];
  result_word_t expected_rows[$];

  // predictor state: width register and the two held rows
  logic [ROW_WIDTH_W-1:0] width_q = ROW_WIDTH_RESET;
  logic [CELLS-1:0]       held_upper = '0;
  logic [CELLS-1:0]       held_middle = '0;

  int failures = 0;

  life_generation_row_stepper_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // b3/s23 over three rows, all eight neighbours, dead outside the grid
  function automatic logic [CELLS-1:0] life_next_row(input logic [CELLS-1:0] above,
                                                     input logic [CELLS-1:0] mid,
                                                     input logic [CELLS-1:0] below,
                                                     input logic [CELLS-1:0] mask);
    logic [CELLS-1:0] res;
    int n;
    res = '0;
    for (int i = 0; i < CELLS; i++) begin
      n = 0;
      for (int d = -1; d <= 1; d++) begin
        if (i + d >= 0 && i + d < CELLS) begin
          n += int'(above[i+d]) + int'(below[i+d]);
          if (d != 0) n += int'(mid[i+d]);
        end
      end
      if (n == int'(BIRTH_COUNT) || (n == int'(SURVIVE_COUNT) && mid[i])) res[i] = 1'b1;
    end
    return res & mask;
  endfunction

  // next-generation rows caused by one accepted row word
  task automatic predict_next_rows(input row_word_t w);
    logic [CELLS-1:0] mask;
    logic [CELLS-1:0] row;
    result_word_t r;
    mask = (width_q >= 7'd64) ? '1 : ((64'd1 << width_q) - 64'd1);
    row = w.cells & mask;
    if (w.top) begin
      held_upper = '0;
      held_middle = row;
    end else begin
      r.cells = life_next_row(held_upper & mask, held_middle & mask, row, mask);
      r.grid_end = 1'b0;
      r.run_last = !w.bottom;
      expected_rows.push_back(r);
      held_upper = held_middle;
      held_middle = row;
    end
    // bottom row: its own next row with a dead row below
    if (w.bottom) begin
      r.cells = life_next_row(held_upper & mask, held_middle & mask, '0, mask);
      r.grid_end = 1'b1;
      r.run_last = 1'b1;
      expected_rows.push_back(r);
    end
  endtask

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;
  row_word_t next_word;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready) predict_next_rows('{s_tdata, s_tuser, s_tlast});
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          s_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_rows.size() != 0) begin
          next_word = pending_rows.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= next_word.cells;
          s_tuser <= next_word.top;
          s_tlast <= next_word.bottom;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern in segments, plus long hold-offs
  int results_seen = 0;
  int next_hold_at = 120;
  int hold_left = 0;
  int seg_left = 0;
  int stall_mode = 0;
  int seg_cycle = 0;
  logic [7:0] stall_pattern = 8'hff;
  result_word_t want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      // check each accepted result word against the oldest expectation
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_rows.size() == 0) begin
          $error("unexpected word: next_row_cells %h grid_end %b run_last %b",
                 m_tdata, m_tlast, m_tuser);
          failures++;
        end else begin
          want = expected_rows.pop_front();
          if (m_tdata !== want.cells) begin
            $error("next_row_cells: expected %h, got %h", want.cells, m_tdata);
            failures++;
          end
          if (m_tlast !== want.grid_end) begin
            $error("grid_end: expected %b, got %b", want.grid_end, m_tlast);
            failures++;
          end
          if (m_tuser !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, m_tuser);
            failures++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else if (results_seen >= next_hold_at) begin
        // long hold-off so the block backs up and stalls its input
        hold_left <= 300;
        next_hold_at <= next_hold_at + 450;
        m_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left <= $urandom_range(20, 120);
          stall_mode <= $urandom_range(0, 2);
          stall_pattern <= 8'($urandom_range(1, 255));
          seg_cycle <= 0;
        end else begin
          seg_left <= seg_left - 1;
          seg_cycle <= seg_cycle + 1;
        end
        case (stall_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= stall_pattern[seg_cycle % 8];
        endcase
      end
    end
  end

  // row content of various densities
  function automatic logic [CELLS-1:0] random_cells();
    logic [CELLS-1:0] a;
    logic [CELLS-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return a & b & {$urandom, $urandom};
      1: return a | b;
      2: return '1;
      3: return '0;
      4: return 64'h7 << $urandom_range(0, 61);
      default: return a;
    endcase
  endfunction

  task automatic add_row(input logic [CELLS-1:0] cells, input logic top, input logic bottom);
    pending_rows.push_back('{cells, top, bottom});
  endtask

  // mostly whole grids, some loose words with random marks
  task automatic add_random_rows(input int n_items);
    int left;
    int height;
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        add_row(random_cells(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        left--;
      end else begin
        height = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
        for (int r = 0; r < height; r++) add_row(random_cells(), r == 0, r == height - 1);
        left -= height;
      end
    end
  endtask

  // wait until every word is in and every result is out, then let the pipe drain
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_rows.size() != 0 || s_tvalid || expected_rows.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_width(input logic [ROW_WIDTH_W-1:0] w);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    width_q = w;
    @(negedge clk);
  endtask

  logic [ROW_WIDTH_W-1:0] widths[12] = '{7'd1, 7'd0, 7'd127, 7'd65, 7'd2, 7'd3,
                                         7'd63, 7'd64, 7'd17, 7'd40, 7'd0, 7'd0};

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // rows with no top mark straight after reset
    add_row('1, 1'b0, 1'b0);
    add_row(64'h8000_0000_0000_0001, 1'b0, 1'b0);
    // bottom without top: two results
    add_row(64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b1);
    // no top mark after a bottom row
    add_row('1, 1'b0, 1'b0);
    add_row(64'h5555_5555_5555_5555, 1'b0, 1'b1);
    // single-row grids
    add_row(64'h7, 1'b1, 1'b1);
    add_row('1, 1'b1, 1'b1);
    add_row('0, 1'b1, 1'b1);
    add_row(64'he000_0000_0000_0000, 1'b1, 1'b1);
    // vertical blinker against column 0
    add_row(64'h2, 1'b1, 1'b0);
    add_row(64'h2, 1'b0, 1'b0);
    add_row(64'h2, 1'b0, 1'b1);
    // block in the top lanes, then a dead row
    add_row(64'hc000_0000_0000_0000, 1'b1, 1'b0);
    add_row(64'hc000_0000_0000_0000, 1'b0, 1'b0);
    add_row('0, 1'b0, 1'b1);
    // top row not closed, then a new grid
    add_row(64'hffff_0000_ffff_0000, 1'b1, 1'b0);
    // glider
    add_row(64'h2, 1'b1, 1'b0);
    add_row(64'h4, 1'b0, 1'b0);
    add_row(64'h7, 1'b0, 1'b0);
    add_row('0, 1'b0, 1'b1);
    // dense grid
    add_row('1, 1'b1, 1'b0);
    add_row('1, 1'b0, 1'b0);
    add_row('1, 1'b0, 1'b1);
    wait_idle();

    // random phases across widths, extremes among them
    widths[10] = ROW_WIDTH_W'($urandom_range(0, 127));
    widths[11] = ROW_WIDTH_W'($urandom_range(0, 127));
    foreach (widths[k]) begin
      write_width(widths[k]);
      add_random_rows(75);
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (failures == 0 && expected_rows.size() == 0) begin
      $display("life_generation_row_stepper_unit: match");
    end else begin
      $display("life_generation_row_stepper_unit: mismatch");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #2000000;
    $display("life_generation_row_stepper_unit: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
src/lgrs_pkg.sv
src/lgrs_next_gen.sv
src/life_generation_row_stepper_unit.sv
tb/tb.sv
